FILE: rtl/core/llrp_pkg.sv
// Package for the least-loaded row packer: widths, register indexes,
// sequencer step codes and the control-store contents.
// No dependencies.
`timescale 1ns / 1ps

package llrp_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
  localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int WIDTH_W    = 20;
  localparam int ITEM_W     = 12;
  localparam int GAP_W      = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP       = 1'b1;

  // Sequencer steps (addresses of the control store).
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_SCAN,
    STEP_UPDATE
  } step_t;

  // Branch conditions tested by a control word.
  typedef enum logic [1:0] {
    COND_IN_VALID,
    COND_SCAN_DONE,
    COND_OUT_FREE
  } cond_t;

  // One control word: datapath strobes plus a two-way branch.
  typedef struct packed {
    logic  take_item;
    logic  scan;
    logic  update;
    cond_t cond;
    step_t target_true;
    step_t target_false;
  } ucode_t;

  // Control store: a three-step program.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{take_item: 1'b0, scan: 1'b0, update: 1'b0, cond: COND_IN_VALID,
          target_true: STEP_IDLE, target_false: STEP_IDLE};
    unique case (s)
      STEP_IDLE: begin
        w.take_item    = 1'b1;
        w.cond         = COND_IN_VALID;
        w.target_true  = STEP_SCAN;
        w.target_false = STEP_IDLE;
      end
      STEP_SCAN: begin
        w.scan         = 1'b1;
        w.cond         = COND_SCAN_DONE;
        w.target_true  = STEP_UPDATE;
        w.target_false = STEP_SCAN;
      end
      STEP_UPDATE: begin
        w.update       = 1'b1;
        w.cond         = COND_OUT_FREE;
        w.target_true  = STEP_IDLE;
        w.target_false = STEP_UPDATE;
      end
      default: begin
        w.cond         = COND_IN_VALID;
        w.target_true  = STEP_IDLE;
        w.target_false = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/least_loaded_row_packer.sv
// Least-loaded row packer: a microcoded sequencer over a row-width register file.
// Depends on llrp_pkg (widths, register indexes, control store).
//
// Usage: item widths arrive on the s_ stream (tdata holds item_width, tlast
// marks the last item of a set). For each item the block picks the narrowest
// row in use (lowest index on a tie), adds item_width plus gap to it with
// saturation, and returns one item on the m_ stream: chosen_row and the
// widest row so far in tdata, with tlast set when the item closed the set.
// Closing a set puts every row and the running maximum back to gap.
// Configuration (row_count, gap) goes through cfg_we/cfg_addr/cfg_wdata while
// the block is idle; any write to a known register restarts the set.
// Steps: the idle step takes the item, then the scan step visits the rows in
// use one at a time (its last visit only ends the scan), then the update step
// writes the row and the result. The single compare in the scan step reads
// one row per cycle. The result sits in an output register; a new item is
// taken while it waits, but the update step of that next item holds until
// the receiver has taken the previous result.
// Reset (rst, synchronous) sets row_count to 1, gap to 0 and empties all rows.
`timescale 1ns / 1ps

module least_loaded_row_packer (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream. tdata: item_width [11:0], zeros [15:12]. tlast: final_item.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [llrp_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  // Output stream. tdata: chosen_row [3:0], widest_row [23:4]. tlast: set_done.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [llrp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [llrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [llrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import llrp_pkg::*;

  // Configuration registers.
  logic [ROW_CNT_W-1:0] row_count;
  logic [GAP_W-1:0]     gap;

  // Row widths; a row whose valid bit is clear reads as gap.
  logic [WIDTH_W-1:0]   row_width [MAX_ROWS];
  logic [MAX_ROWS-1:0]  row_valid;
  logic [WIDTH_W-1:0]   running_max;

  // Item and scan registers.
  logic [ITEM_W-1:0]    item_width;
  logic                 final_item;
  logic [ROW_CNT_W-1:0] scan_idx;
  logic [ROW_IDX_W-1:0] best;
  logic [WIDTH_W-1:0]   best_val;

  // Sequencer.
  step_t                step;
  step_t                step_next;
  ucode_t               uw;
  logic                 cond_true;

  // Datapath signals.
  logic [ROW_CNT_W-1:0] rows_in_use;
  logic [WIDTH_W-1:0]   scan_val;
  logic [WIDTH_W-1:0]   row0_val;
  logic [WIDTH_W:0]     sum_wide;
  logic [WIDTH_W-1:0]   sum;
  logic [WIDTH_W-1:0]   new_max;
  logic                 out_free;
  logic                 scan_done;
  logic                 in_fire;
  logic                 upd_fire;
  logic                 cfg_hit;
  logic [GAP_W-1:0]     gap_after_cfg;

  // Rows in use: zero counts as one, above the maximum saturates.
  always_comb begin
    if (row_count == '0) begin
      rows_in_use = ROW_CNT_W'(1);
    end else if (row_count > ROW_CNT_W'(MAX_ROWS)) begin
      rows_in_use = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_in_use = row_count;
    end
  end

  // Row reads: one at the scan index, one at row zero for the scan start.
  assign scan_val = row_valid[scan_idx[ROW_IDX_W-1:0]] ?
                    row_width[scan_idx[ROW_IDX_W-1:0]] : WIDTH_W'(gap);
  assign row0_val = row_valid[0] ? row_width[0] : WIDTH_W'(gap);

  // Saturating add and the new running maximum.
  assign sum_wide = {1'b0, best_val} + (WIDTH_W + 1)'(item_width) + (WIDTH_W + 1)'(gap);
  assign sum      = sum_wide[WIDTH_W] ? WIDTH_MAX : sum_wide[WIDTH_W-1:0];
  assign new_max  = (sum > running_max) ? sum : running_max;

  // Branch conditions.
  assign out_free  = !m_tvalid || m_tready;
  assign scan_done = scan_idx >= rows_in_use;

  // Control word fetch and condition select.
  always_comb begin
    uw = ucode_rom(step);
    case (uw.cond)
      COND_IN_VALID:  cond_true = s_tvalid;
      COND_SCAN_DONE: cond_true = scan_done;
      COND_OUT_FREE:  cond_true = out_free;
      default:        cond_true = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    step_next = cond_true ? uw.target_true : uw.target_false;
  end

  // Control outputs.
  always_comb begin
    s_tready = uw.take_item;
    in_fire  = uw.take_item && s_tvalid;
    upd_fire = uw.update && out_free;
  end

  assign cfg_hit       = cfg_we && (cfg_addr == REG_ROW_COUNT || cfg_addr == REG_GAP);
  assign gap_after_cfg = (cfg_addr == REG_GAP) ? cfg_wdata[GAP_W-1:0] : gap;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_CNT_W'(1);
      gap       <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_ROW_COUNT) begin
        row_count <= cfg_wdata[ROW_CNT_W-1:0];
      end else if (cfg_addr == REG_GAP) begin
        gap <= cfg_wdata[GAP_W-1:0];
      end
    end
  end

  // Row valid bits and running maximum; a set restart clears the valid bits and puts the maximum back to gap.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      running_max <= '0;
    end else if (cfg_hit) begin
      row_valid   <= '0;
      running_max <= WIDTH_W'(gap_after_cfg);
    end else if (upd_fire) begin
      if (final_item) begin
        row_valid   <= '0;
        running_max <= WIDTH_W'(gap);
      end else begin
        row_valid[best] <= 1'b1;
        running_max     <= new_max;
      end
    end
  end

  // Row width storage.
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      row_width[best] <= sum;
    end
  end

  // Item capture and the scan over the rows.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_width <= s_tdata[ITEM_W-1:0];
      final_item <= s_tlast;
      scan_idx   <= ROW_CNT_W'(1);
      best       <= '0;
      best_val   <= row0_val;
    end else if (uw.scan && !scan_done) begin
      if (scan_val < best_val) begin
        best     <= scan_idx[ROW_IDX_W-1:0];
        best_val <= scan_val;
      end
      scan_idx <= scan_idx + ROW_CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= {new_max, best};
      m_tlast <= final_item;
    end
  end

  // The scan never compares row zero against itself.
  assert property (@(posedge clk) disable iff (rst)
    step == STEP_SCAN |-> scan_idx != '0)
    else $error("scan index reached zero");

  // The row being updated lies within the rows in use.
  assert property (@(posedge clk) disable iff (rst)
    step == STEP_UPDATE |-> ROW_CNT_W'(best) < rows_in_use)
    else $error("chosen row outside rows in use");

  // Every update leaves a result waiting in the output register.
  assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> m_tvalid)
    else $error("update produced no result");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for least_loaded_row_packer: streams glyph widths in
// sets, predicts each row choice and widest row, and checks every result item.
// Depends on llrp_pkg and the least_loaded_row_packer RTL.
`timescale 1ns / 1ps

module tb_top;
  import llrp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_PAUSE = 24;

  typedef struct {
    logic [ITEM_W-1:0] width;
    logic              last;
  } glyph_t;

  typedef struct {
    logic [ROW_IDX_W-1:0] row;
    logic [WIDTH_W-1:0]   widest;
    logic                 done;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  glyph_t     glyph_queue[$];
  placement_t placements_due[$];
  int         send_idle_pct = 6;
  int         recv_idle_pct = 87;
  int         errors = 0;
  int         cycles = 0;

  // Predictor state: the row widths, the widest row and both registers.
  logic [WIDTH_W-1:0]   row_fill[MAX_ROWS];
  logic [WIDTH_W-1:0]   peak_width;
  logic [ROW_CNT_W-1:0] rows_setting;
  logic [GAP_W-1:0]     gap_setting;

  least_loaded_row_packer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Every row and the widest row go back to the padding value.
  function automatic void restart_rows();
    for (int i = 0; i < MAX_ROWS; i++) row_fill[i] = WIDTH_MAX & gap_setting;
    peak_width = WIDTH_MAX & gap_setting;
  endfunction

  // Place one glyph on the narrowest row in use and report the outcome.
  function automatic placement_t place_glyph(input logic [ITEM_W-1:0] width,
                                             input logic last);
    placement_t  res;
    int unsigned active;
    int unsigned best;
    int unsigned sum;
    active = (rows_setting == 0) ? 1 : (rows_setting > MAX_ROWS) ? MAX_ROWS : rows_setting;
    best = 0;
    for (int unsigned i = 1; i < active; i++)
      if (row_fill[i] < row_fill[best]) best = i;
    sum = row_fill[best] + width + gap_setting;
    if (sum > WIDTH_MAX) sum = WIDTH_MAX;
    row_fill[best] = sum[WIDTH_W-1:0];
    if (row_fill[best] > peak_width) peak_width = row_fill[best];
    res.row    = best[ROW_IDX_W-1:0];
    res.widest = peak_width;
    res.done   = last;
    if (last) restart_rows();
    return res;
  endfunction

  // Sender: predicts on each accepted item and presents the next one.
  always @(posedge clk) begin
    glyph_t nxt;
    if (rst) begin
      s_tvalid     <= 1'b0;
      rows_setting = 1;
      gap_setting  = '0;
      restart_rows();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ROW_COUNT) rows_setting = cfg_wdata[ROW_CNT_W-1:0];
        else gap_setting = cfg_wdata[GAP_W-1:0];
        restart_rows();
      end
      if (s_tvalid && s_tready)
        placements_due.insert(placements_due.size(),
                              place_glyph(s_tdata[ITEM_W-1:0], s_tlast));
      if (!s_tvalid || s_tready) begin
        if (glyph_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = glyph_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(IN_DATA_W-ITEM_W){1'b0}}, nxt.width};
          s_tlast  <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (placements_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = placements_due.pop_front();
          if (m_tdata[ROW_IDX_W-1:0] !== want.row) begin
            $display("%0t: chosen_row expected %0d, actual %0d",
                     $time, want.row, m_tdata[ROW_IDX_W-1:0]);
            errors++;
          end
          if (m_tdata[ROW_IDX_W +: WIDTH_W] !== want.widest) begin
            $display("%0t: widest_row expected %0d, actual %0d",
                     $time, want.widest, m_tdata[ROW_IDX_W +: WIDTH_W]);
            errors++;
          end
          if (m_tlast !== want.done) begin
            $display("%0t: set_done expected %b, actual %b", $time, want.done, m_tlast);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_glyph(input int width, input bit last);
    glyph_t g;
    g.width = width[ITEM_W-1:0];
    g.last  = last;
    glyph_queue.insert(glyph_queue.size(), g);
  endtask

  // Wait until every item has been sent and every result has come back.
  task automatic wait_drained();
    while (glyph_queue.size() != 0 || placements_due.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Reprogram both registers once the block is idle; spare high bits of the
  // row count write are random so that the field masking is exercised.
  task automatic set_layout(input int rows, input int gap_val);
    int rows_word;
    wait_drained();
    rows_word = ($urandom_range(15) << ROW_CNT_W) | rows;
    if ($urandom_range(1)) begin
      write_reg(REG_ROW_COUNT, rows_word);
      write_reg(REG_GAP, gap_val);
    end else begin
      write_reg(REG_GAP, gap_val);
      write_reg(REG_ROW_COUNT, rows_word);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_width();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 4095;
      2, 3, 4: return $urandom_range(63);
      default: return $urandom_range(4095);
    endcase
  endfunction

  function automatic int pick_rows();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(17, 31);
      2:       return MAX_ROWS;
      default: return $urandom_range(1, MAX_ROWS);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 511;
      default: return $urandom_range(511);
    endcase
  endfunction

  // Mostly complete sets with random content; some sets carry stray final
  // marks or never close, so a register write cuts them short.
  task automatic random_stretch(input int quota, input bit with_saturation);
    int issued;
    int len;
    int shape;
    bit last;
    issued = 0;
    if (with_saturation) begin
      // One row filled far enough for its width to saturate.
      set_layout(1, 511);
      for (int i = 0; i < 235; i++) add_glyph(4095 - $urandom_range(3), i == 234);
      issued += 235;
    end
    while (issued < quota) begin
      set_layout(pick_rows(), pick_gap());
      repeat ($urandom_range(2, 6)) begin
        len   = $urandom_range(1, 24);
        shape = $urandom_range(7);
        for (int i = 0; i < len; i++) begin
          if (shape == 0) last = ($urandom_range(7) == 0);
          else if (shape == 1) last = 1'b0;
          else last = (i == len - 1);
          add_glyph(pick_width(), last);
          issued++;
        end
      end
    end
  endtask

  // Stimulus sequencing and the final verdict.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: one row, no padding.
    add_glyph(0, 1'b0);
    add_glyph(4095, 1'b0);
    add_glyph(7, 1'b1);
    // Ties across three rows, then uneven widths.
    set_layout(3, 0);
    add_glyph(0, 1'b0);
    add_glyph(0, 1'b0);
    add_glyph(10, 1'b0);
    add_glyph(5, 1'b0);
    add_glyph(5, 1'b0);
    add_glyph(4095, 1'b1);
    // All sixteen rows with the largest padding, wrapping back to row zero.
    set_layout(MAX_ROWS, 511);
    for (int i = 0; i < 17; i++) add_glyph(4095, i == 16);
    // A row count of zero behaves as one row.
    set_layout(0, 5);
    add_glyph(100, 1'b0);
    add_glyph(200, 1'b1);
    // A row count above the row limit is clamped to it.
    set_layout(31, 1);
    add_glyph(1, 1'b0);
    add_glyph(2, 1'b1);

    random_stretch(550, 1'b0);
    wait_drained();
    send_idle_pct = 87;
    recv_idle_pct = 6;
    random_stretch(550, 1'b1);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stretch(550, 1'b0);
    wait_drained();

    if (errors == 0 && placements_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/llrp_pkg.sv
rtl/core/least_loaded_row_packer.sv
test/tb_top.sv
